>>> hdl/ricd_pkg.sv
package ricd_pkg;

  // table geometry
  localparam int ENTRIES          = 64;
  localparam int IDX_W            = $clog2(ENTRIES);
  localparam int INODES_PER_BLOCK = 8;
  localparam int OFF_W            = $clog2(INODES_PER_BLOCK);
  localparam int REFS_W           = 16;
  localparam logic [REFS_W-1:0] REFS_MAX = {REFS_W{1'b1}};

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [0:0] REG_INODE_TABLE_START = 1'b0;

  // request commands
  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  // result status codes
  localparam logic [2:0] ST_HIT       = 3'd0;
  localparam logic [2:0] ST_LOADED    = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_KEPT      = 3'd3;
  localparam logic [2:0] ST_WRITEBACK = 3'd4;
  localparam logic [2:0] ST_NULL      = 3'd5;
  localparam logic [2:0] ST_UNDERFLOW = 3'd6;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  device_id;
    logic [31:0] inode_number;
    logic [6:0]  slot;
    logic        entry_dirty;
  } in_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  entry_slot;
    logic [7:0]  disk_device;
    logic [31:0] disk_block;
    logic [2:0]  block_offset;
  } out_rsp_t;

  // one table entry as stored in the RAM
  typedef struct packed {
    logic [7:0]        dev;
    logic [31:0]       ino;
    logic [REFS_W-1:0] refs;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic             re;
    logic [IDX_W-1:0] raddr;
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
  } ram_req_t;

endpackage

>>> hdl/ricd_ram.sv
module ricd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/ricd_cfg.sv
module ricd_cfg import ricd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [31:0]           table_start
);

  logic [31:0] table_start_r;
  logic [31:0] table_start_nxt;
  logic        sel_start;

  // word index is paddr[2]; only index 0 exists
  assign sel_start = (paddr[2] == REG_INODE_TABLE_START);

  always_comb begin
    table_start_nxt = table_start_r;
    if (psel && penable && pwrite && sel_start) begin
      table_start_nxt = pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_start_r <= '0;
    end else begin
      table_start_r <= table_start_nxt;
    end
  end

  assign pready      = 1'b1;
  assign prdata      = sel_start ? table_start_r : '0;
  assign table_start = table_start_r;

endmodule

>>> hdl/ricd_engine.sv
module ricd_engine import ricd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_req_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_rsp_t    out_data,
  input  logic [31:0] table_start,
  output ram_req_t    ram_req,
  input  entry_t      ram_rdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_PUT_RD,
    S_DECIDE,
    S_FIN
  } state_t;

  state_t             state_r, state_nxt;
  in_req_t            req_r, req_nxt;
  logic [IDX_W:0]     scan_addr_r, scan_addr_nxt;
  logic               cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]   cmp_idx_r, cmp_idx_nxt;
  logic               cmp_used_r, cmp_used_nxt;
  logic               hit_r, hit_nxt;
  logic [IDX_W-1:0]   hit_idx_r, hit_idx_nxt;
  logic [REFS_W-1:0]  hit_refs_r, hit_refs_nxt;
  logic               free_r, free_nxt;
  logic [IDX_W-1:0]   free_idx_r, free_idx_nxt;
  logic [ENTRIES-1:0] valid_r, valid_nxt;
  out_rsp_t           pend_r, pend_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_rsp_t           rsp_r, rsp_nxt;

  logic               issue;
  logic [IDX_W-1:0]   scan_idx;
  logic [IDX_W-1:0]   put_idx;
  logic               slot_null;
  logic [REFS_W-1:0]  cmp_refs;
  logic               cmp_match;
  logic [REFS_W-1:0]  refs_dec;
  logic [7:0]         acc_dev;
  logic [31:0]        acc_ino;
  logic [31:0]        ino_m1;
  logic [31:0]        acc_block;
  logic [2:0]         acc_off;

  assign issue     = (scan_addr_r < (IDX_W+1)'(ENTRIES));
  assign scan_idx  = scan_addr_r[IDX_W-1:0];
  assign put_idx   = IDX_W'(req_r.slot);
  assign slot_null = (32'(in_data.slot) >= 32'(ENTRIES));

  // an entry that was never claimed reads as count zero, no key
  assign cmp_refs  = cmp_used_r ? ram_rdata.refs : '0;
  assign cmp_match = cmp_used_r && (ram_rdata.dev == req_r.device_id) &&
                     (ram_rdata.ino == req_r.inode_number);
  assign refs_dec  = cmp_refs - REFS_W'(1);

  // disk location: load uses the requested key, write back the stored one
  assign acc_dev   = (req_r.cmd == CMD_GET) ? req_r.device_id : ram_rdata.dev;
  assign acc_ino   = (req_r.cmd == CMD_GET) ? req_r.inode_number : ram_rdata.ino;
  assign ino_m1    = acc_ino - 32'd1;
  assign acc_block = table_start + (ino_m1 >> OFF_W);
  assign acc_off   = 3'(ino_m1[OFF_W-1:0]);

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    scan_addr_nxt = scan_addr_r;
    cmp_vld_nxt   = 1'b0;
    cmp_idx_nxt   = cmp_idx_r;
    cmp_used_nxt  = cmp_used_r;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    hit_refs_nxt  = hit_refs_r;
    free_nxt      = free_r;
    free_idx_nxt  = free_idx_r;
    valid_nxt     = valid_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r && !out_ready;
    rsp_nxt       = rsp_r;
    ram_req       = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt       = in_data;
          hit_nxt       = 1'b0;
          free_nxt      = 1'b0;
          scan_addr_nxt = '0;
          if (in_data.cmd == CMD_GET) begin
            state_nxt = S_SCAN;
          end else if (slot_null) begin
            pend_nxt        = '0;
            pend_nxt.status = ST_NULL;
            state_nxt       = S_FIN;
          end else begin
            state_nxt = S_PUT_RD;
          end
        end
      end

      S_SCAN: begin
        if (issue) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = scan_idx;
          scan_addr_nxt = scan_addr_r + (IDX_W+1)'(1);
          cmp_vld_nxt   = 1'b1;
          cmp_idx_nxt   = scan_idx;
          cmp_used_nxt  = valid_r[scan_idx];
        end
        if (cmp_vld_r) begin
          if (cmp_match && !hit_r) begin
            hit_nxt      = 1'b1;
            hit_idx_nxt  = cmp_idx_r;
            hit_refs_nxt = ram_rdata.refs;
          end
          if ((cmp_refs == '0) && !free_r) begin
            free_nxt     = 1'b1;
            free_idx_nxt = cmp_idx_r;
          end
          if (!issue) begin
            state_nxt = S_DECIDE;
          end
        end
      end

      S_PUT_RD: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = put_idx;
        cmp_used_nxt  = valid_r[put_idx];
        state_nxt     = S_DECIDE;
      end

      S_DECIDE: begin
        pend_nxt  = '0;
        state_nxt = S_FIN;
        if (req_r.cmd == CMD_GET) begin
          if (hit_r) begin
            ram_req.we         = 1'b1;
            ram_req.waddr      = hit_idx_r;
            ram_req.wdata.dev  = req_r.device_id;
            ram_req.wdata.ino  = req_r.inode_number;
            ram_req.wdata.refs = (hit_refs_r == REFS_MAX) ? hit_refs_r
                                                          : hit_refs_r + REFS_W'(1);
            pend_nxt.status     = ST_HIT;
            pend_nxt.entry_slot = 6'(hit_idx_r);
          end else if (free_r) begin
            ram_req.we              = 1'b1;
            ram_req.waddr           = free_idx_r;
            ram_req.wdata.dev       = req_r.device_id;
            ram_req.wdata.ino       = req_r.inode_number;
            ram_req.wdata.refs      = REFS_W'(1);
            valid_nxt[free_idx_r]   = 1'b1;
            pend_nxt.status         = ST_LOADED;
            pend_nxt.entry_slot     = 6'(free_idx_r);
            pend_nxt.disk_device    = acc_dev;
            pend_nxt.disk_block     = acc_block;
            pend_nxt.block_offset   = acc_off;
          end else begin
            pend_nxt.status = ST_FULL;
          end
        end else begin
          pend_nxt.entry_slot = 6'(put_idx);
          if (cmp_refs == '0) begin
            pend_nxt.status = ST_UNDERFLOW;
          end else begin
            ram_req.we         = 1'b1;
            ram_req.waddr      = put_idx;
            ram_req.wdata      = ram_rdata;
            ram_req.wdata.refs = refs_dec;
            if ((refs_dec != '0) || !req_r.entry_dirty) begin
              pend_nxt.status = ST_KEPT;
            end else begin
              pend_nxt.status       = ST_WRITEBACK;
              pend_nxt.disk_device  = acc_dev;
              pend_nxt.disk_block   = acc_block;
              pend_nxt.block_offset = acc_off;
            end
          end
        end
      end

      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          rsp_nxt       = pend_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cmp_vld_r   <= 1'b0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      hit_r       <= hit_nxt;
      free_r      <= free_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
      req_r       <= req_nxt;
      scan_addr_r <= scan_addr_nxt;
      cmp_idx_r   <= cmp_idx_nxt;
      cmp_used_r  <= cmp_used_nxt;
      hit_idx_r   <= hit_idx_nxt;
      hit_refs_r  <= hit_refs_nxt;
      free_idx_r  <= free_idx_nxt;
      pend_r      <= pend_nxt;
      rsp_r       <= rsp_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = rsp_r;

endmodule

>>> hdl/refcounted_inode_cache_directory_top.sv
// Channel | Ports                                  | Moves
// --------+----------------------------------------+-------------------------------
// in      | in_valid, in_ready, in_data            | get/put request (in_req_t)
// out     | out_valid, out_ready, out_data         | one result per request (out_rsp_t)
// cfg     | cfg_psel/penable/pwrite/paddr/pwdata,  | inode_table_start at byte 0
//         | cfg_prdata, cfg_pready                 |
//
// A get makes one pass over the entry RAM, one read per cycle, and finds the
// first key match and the first free entry together. A put reads its entry
// once and writes it back with a lower count unless the count is already zero.
// A null put skips the RAM. One request is in flight at a time; in_ready is high
// whenever the engine is idle, even while the last result waits in the output
// register. Synchronous active-low reset clears the valid bits at once, and an
// entry without its valid bit reads as count zero; no clearing pass is needed.
module refcounted_inode_cache_directory_top import ricd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // request channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_req_t               in_data,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_rsp_t              out_data,
  // register port
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  logic [31:0] table_start;
  ram_req_t    ram_req;
  entry_t      ram_rdata;

  // inode table base register
  ricd_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (cfg_psel),
    .penable     (cfg_penable),
    .pwrite      (cfg_pwrite),
    .paddr       (cfg_paddr),
    .pwdata      (cfg_pwdata),
    .prdata      (cfg_prdata),
    .pready      (cfg_pready),
    .table_start (table_start)
  );

  // control: scan, read-modify-write, result staging
  ricd_engine u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .table_start (table_start),
    .ram_req     (ram_req),
    .ram_rdata   (ram_rdata)
  );

  // entry store: {device, inode, count}; key fields are only trusted where
  // the engine's valid bit is set
  ricd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

endmodule

>>> hdl/ricd_checker.sv
module ricd_checker import ricd_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input in_req_t               in_data,
  input logic                  out_valid,
  input logic                  out_ready,
  input out_rsp_t              out_data,
  input logic                  cfg_psel,
  input logic                  cfg_penable,
  input logic                  cfg_pwrite,
  input logic [CFG_ADDR_W-1:0] cfg_paddr,
  input logic [CFG_DATA_W-1:0] cfg_pwdata,
  input logic [CFG_DATA_W-1:0] cfg_prdata,
  input logic                  cfg_pready
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one request at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while previous one in flight");

  // only loads and write backs carry a disk location
  a_no_access_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_HIT || out_data.status == ST_FULL ||
                  out_data.status == ST_KEPT || out_data.status == ST_NULL ||
                  out_data.status == ST_UNDERFLOW)
    |-> out_data.disk_device == '0 && out_data.disk_block == '0 &&
        out_data.block_offset == '0)
    else $error("disk location on a result without disk access");

  // full and null results name no slot
  a_full_null_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_FULL || out_data.status == ST_NULL)
    |-> out_data.entry_slot == '0)
    else $error("slot set on full or null result");

  // a written base register reads back
  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == '0
    |=> (cfg_paddr != '0) || (cfg_prdata == $past(cfg_pwdata)))
    else $error("inode table start did not read back");

endmodule

bind refcounted_inode_cache_directory_top ricd_checker u_ricd_checker (.*);
